// ----- hdl/wbps_pkg.sv -----
// shared types, register indexes and constants of the wildcard byte pattern scanner
`default_nettype none

package wbps_pkg;

    // fixed field and register widths
    localparam int BYTE_W     = 8;
    localparam int ADDR_W     = 32;
    localparam int LEN_W      = 5;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 2;
    localparam int PAT_BYTES  = 16;
    localparam int PAT_IDX_W  = 4;

    // pattern byte that matches any data byte
    localparam logic [BYTE_W-1:0] WILDCARD_BYTE = 8'h2A;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PATTERN_LOW    = 2'd0,
        REG_PATTERN_HIGH   = 2'd1,
        REG_PATTERN_LENGTH = 2'd2,
        REG_SEARCH_BASE    = 2'd3
    } reg_index_t;

    // configuration as seen by the matcher
    typedef struct packed {
        logic [PAT_BYTES*BYTE_W-1:0] pattern;
        logic [LEN_W-1:0]            length;
        logic [ADDR_W-1:0]           base;
    } cfg_t;

    // one result word
    typedef struct packed {
        logic              found;
        logic [ADDR_W-1:0] address;
    } result_t;

    // pattern byte idx out of the packed 16-byte pattern
    function automatic logic [BYTE_W-1:0] pattern_byte(
        input logic [PAT_BYTES*BYTE_W-1:0] pattern,
        input logic [PAT_IDX_W-1:0]        idx
    );
        pattern_byte = pattern[idx*BYTE_W +: BYTE_W];
    endfunction

endpackage

`default_nettype wire

// ----- hdl/wbps_cfg.sv -----
// configuration registers of the wildcard byte pattern scanner
`default_nettype none

module wbps_cfg (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_wen,
    input  wire logic [wbps_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [wbps_pkg::CFG_DATA_W-1:0]     cfg_data,
    output wbps_pkg::cfg_t                           cfg
);

    logic [wbps_pkg::CFG_DATA_W-1:0] pat_low_reg;
    logic [wbps_pkg::CFG_DATA_W-1:0] pat_high_reg;
    logic [wbps_pkg::LEN_W-1:0]      length_reg;
    logic [wbps_pkg::ADDR_W-1:0]     base_reg;

    // register writes, one index per write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_low_reg  <= '0;
            pat_high_reg <= '0;
            length_reg   <= wbps_pkg::LEN_W'(1);
            base_reg     <= '0;
        end
        else if (cfg_wen)
        begin
            unique case (wbps_pkg::reg_index_t'(cfg_index))
                wbps_pkg::REG_PATTERN_LOW:    pat_low_reg  <= cfg_data;
                wbps_pkg::REG_PATTERN_HIGH:   pat_high_reg <= cfg_data;
                wbps_pkg::REG_PATTERN_LENGTH: length_reg   <= cfg_data[wbps_pkg::LEN_W-1:0];
                wbps_pkg::REG_SEARCH_BASE:    base_reg     <= cfg_data[wbps_pkg::ADDR_W-1:0];
                default:                      ;
            endcase
        end
    end

    assign cfg.pattern = {pat_high_reg, pat_low_reg};
    assign cfg.length  = length_reg;
    assign cfg.base    = base_reg;

endmodule

`default_nettype wire

// ----- hdl/wbps_match.sv -----
// byte window, parallel wildcard compare and per-region scan state
`default_nettype none

module wbps_match (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            step,
    input  wire logic [wbps_pkg::BYTE_W-1:0]     data_byte,
    input  wire logic                            last_byte,
    input  wbps_pkg::cfg_t                       cfg,
    output logic                                 result_valid,
    output wbps_pkg::result_t                    result
);

    localparam int MAX_PATTERN = wbps_pkg::PAT_BYTES;
    localparam int WIN_D = (MAX_PATTERN > 1) ? MAX_PATTERN - 1 : 1;

    logic [wbps_pkg::BYTE_W-1:0] win_reg  [WIN_D];
    logic [wbps_pkg::BYTE_W-1:0] win_next [WIN_D];
    logic [wbps_pkg::ADDR_W-1:0] seen_reg;
    logic [wbps_pkg::ADDR_W-1:0] seen_next;
    logic                        reported_reg;
    logic                        reported_next;

    logic [wbps_pkg::BYTE_W-1:0] hist [MAX_PATTERN];
    logic [MAX_PATTERN-1:0]      lane_ok;
    logic [wbps_pkg::LEN_W-1:0]  eff_len;
    logic [wbps_pkg::ADDR_W-1:0] count;
    logic                        enough;
    logic                        hit;
    logic                        match_now;

    // clamp the length register into 1..MAX_PATTERN
    always_comb
    begin
        priority if (cfg.length == '0)
            eff_len = wbps_pkg::LEN_W'(1);
        else if (cfg.length > wbps_pkg::LEN_W'(MAX_PATTERN))
            eff_len = wbps_pkg::LEN_W'(MAX_PATTERN);
        else
            eff_len = cfg.length;
    end

    // history view: lane 0 is the arriving byte, lane j the byte j back
    assign hist[0] = data_byte;
    for (genvar j = 1; j < MAX_PATTERN; j++)
    begin : g_hist
        assign hist[j] = win_reg[j-1];
    end

    // lane j meets pattern byte len-1-j; lanes beyond the length always pass
    for (genvar j = 0; j < MAX_PATTERN; j++)
    begin : g_lane
        logic [wbps_pkg::LEN_W-1:0]  pidx;
        logic [wbps_pkg::BYTE_W-1:0] pbyte;
        assign pidx  = eff_len - wbps_pkg::LEN_W'(j) - wbps_pkg::LEN_W'(1);
        assign pbyte = wbps_pkg::pattern_byte(cfg.pattern, pidx[wbps_pkg::PAT_IDX_W-1:0]);
        assign lane_ok[j] = (wbps_pkg::LEN_W'(j) >= eff_len)
                          || (pbyte == wbps_pkg::WILDCARD_BYTE)
                          || (pbyte == hist[j]);
    end

    assign hit = &lane_ok;

    // saturating byte count including the arriving byte
    assign count  = (seen_reg == '1) ? seen_reg : seen_reg + wbps_pkg::ADDR_W'(1);
    assign enough = count >= wbps_pkg::ADDR_W'(eff_len);

    assign match_now = !reported_reg && enough && hit;

    // result of the current word: first match, or not-found at region end
    assign result_valid   = match_now || (last_byte && !reported_reg);
    assign result.found   = match_now;
    assign result.address = match_now
                          ? cfg.base + count - wbps_pkg::ADDR_W'(eff_len)
                          : '0;

    // next scan state: shift the window or start a new region
    always_comb
    begin
        if (last_byte)
        begin
            for (int k = 0; k < WIN_D; k++)
                win_next[k] = '0;
            seen_next     = '0;
            reported_next = 1'b0;
        end
        else
        begin
            win_next[0] = data_byte;
            for (int k = 1; k < WIN_D; k++)
                win_next[k] = win_reg[k-1];
            seen_next     = count;
            reported_next = reported_reg || match_now;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < WIN_D; k++)
                win_reg[k] <= '0;
            seen_reg     <= '0;
            reported_reg <= 1'b0;
        end
        else if (step)
        begin
            win_reg      <= win_next;
            seen_reg     <= seen_next;
            reported_reg <= reported_next;
        end
    end

    // a reported match always belongs to a region with bytes in it
    a_reported_has_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        reported_reg |-> (seen_reg != '0))
        else $error("match reported with empty byte count");

    // the last byte of a region starts a fresh scan
    a_region_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (step && last_byte) |=> ((seen_reg == '0) && !reported_reg))
        else $error("scan state not cleared after last byte");

endmodule

`default_nettype wire

// ----- hdl/wildcard_byte_pattern_scanner_top.sv -----
// top level of the wildcard byte pattern scanner: stream ports and pipeline registers
//
// Usage
//   Slave stream: one byte of the search region per word, s_tdata[7:0] is the
//   byte, s_tlast marks the final byte of the region.
//   Master stream: at most one word per region. m_tuser is the found flag and
//   m_tdata is search_base plus the offset of the first matching byte, or zero
//   with m_tuser low when the region ended without a match.
//   Configuration: cfg_wen writes cfg_data into register cfg_index (0 pattern
//   bytes 0..7, 1 pattern bytes 8..15, 2 pattern length, 3 search base); write
//   only while no byte is in flight. Pattern byte 0x2A matches any byte.
//   Result path: a result word shows on m_tvalid once the byte that completes
//   the match or ends the region has passed the input and output registers.
//   Throughput: one byte per cycle unless the output stalls; the window
//   compare across all pattern lanes sits between the input register and the
//   output register.
//   Reset: scan state and pattern clear, length returns to one, and no separate
//   initialization is needed.
//   Stall: when m_tready is low with a result pending, the input register
//   takes at most one more byte, then s_tready drops until the result leaves.
`default_nettype none

module wildcard_byte_pattern_scanner_top (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [7:0]                          s_tdata,    // data_byte
    input  wire logic                                s_tlast,    // last_byte
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [wbps_pkg::ADDR_W-1:0]              m_tdata,    // match_address
    output logic                                     m_tuser,    // found
    input  wire logic                                cfg_wen,
    input  wire logic [wbps_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [wbps_pkg::CFG_DATA_W-1:0]     cfg_data
);

    wbps_pkg::cfg_t              cfg;
    logic                        in_valid_reg;
    logic [wbps_pkg::BYTE_W-1:0] in_byte_reg;
    logic                        in_last_reg;
    logic                        out_valid_reg;
    wbps_pkg::result_t           out_res_reg;
    logic                        advance;
    logic                        res_valid;
    wbps_pkg::result_t           res;

    wbps_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    wbps_match u_match (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (advance),
        .data_byte    (in_byte_reg),
        .last_byte    (in_last_reg),
        .cfg          (cfg),
        .result_valid (res_valid),
        .result       (res)
    );

    // the held byte moves on when the output register is free or draining
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance && res_valid)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && res_valid)
            out_res_reg <= res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_res_reg.found;
    assign m_tdata  = out_res_reg.address;

    // a not-found word carries a zero address
    a_notfound_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> (m_tdata == '0))
        else $error("not-found word with nonzero address");

    // a held byte that cannot move stays in the input register
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_byte_reg)))
        else $error("input byte lost while output stalled");

endmodule

`default_nettype wire
